// ===== rtl/nau_pkg.sv =====
// shared constants, types and codes for the activation unit
package nau_pkg;

  // fixed-point format of value and result
  localparam int FRAC_BITS = 12;

  // divider geometry: quotient bits, dividend and divisor widths
  localparam int QW   = FRAC_BITS + 1;
  localparam int DIVW = 32 + FRAC_BITS;
  localparam int DSRW = 33;

  // register stages: 6 front, 8 squaring, 1 divide setup, QW divide steps
  localparam int NSTG = 15 + QW;

  // output queue holds every word in flight
  localparam int FIFO_DEPTH = 2 ** $clog2(NSTG + 3);
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef logic [2:0]         op_t;
  typedef logic signed [15:0] fx_t;

  localparam op_t OP_LINEAR  = 3'd0;
  localparam op_t OP_SIGMOID = 3'd1;
  localparam op_t OP_RELU    = 3'd2;
  localparam op_t OP_LEAKY   = 3'd3;
  localparam op_t OP_TANH    = 3'd4;

  // per-word data that rides along the arithmetic stages
  typedef struct packed {
    op_t         op;
    logic        neg;
    logic [15:0] mag;
    fx_t         simple;
  } side_t;

endpackage

// ===== rtl/nau_if.sv =====
// valid/ready channel interfaces for input and result words
interface nau_in_if;
  import nau_pkg::*;
  logic valid;
  logic ready;
  op_t  operation;
  fx_t  value;
  modport source (output valid, output operation, output value, input ready);
  modport sink   (input valid, input operation, input value, output ready);
endinterface

interface nau_out_if;
  import nau_pkg::*;
  logic valid;
  logic ready;
  fx_t  result;
  modport source (output valid, output result, input ready);
  modport sink   (input valid, input result, output ready);
endinterface

// ===== rtl/nau_front.sv =====
// decode, simple activations and exp(-2|x|/256) series in q31
module nau_front (
  input  logic            clk,
  input  nau_pkg::op_t    op_i,
  input  nau_pkg::fx_t    value_i,
  output nau_pkg::side_t  side_o,
  output logic [31:0]     e0_o
);
  import nau_pkg::*;

  localparam int          T_SHIFT    = 24 - FRAC_BITS;
  localparam logic [19:0] EZ_LIM     = 20'(1 << (FRAC_BITS + 3));
  localparam logic [19:0] M6         = 20'((2 ** 22 + 5) / 6);
  localparam logic [15:0] M24        = 16'((2 ** 20 + 23) / 24);
  localparam logic [32:0] Q31_ONE    = 33'd2147483648;
  localparam logic signed [25:0] LEAK_MUL = 26'sd410;
  localparam int          LEAK_SHIFT = 12;

  // stage 0: decode
  side_t        side0_r, side0_nxt;
  logic         ez0_r, ez0_nxt;
  logic [26:0]  t0_r, t0_nxt;
  logic signed [25:0] lk_prod, lk_sh;

  always_comb begin
    side0_nxt.op  = op_i;
    side0_nxt.neg = value_i[15];
    side0_nxt.mag = value_i[15] ? 16'(~value_i + 16'd1) : 16'(value_i);
    lk_prod = 26'(value_i) * LEAK_MUL;
    lk_sh   = lk_prod >>> LEAK_SHIFT;
    case (op_i)
      OP_LINEAR: side0_nxt.simple = value_i;
      OP_RELU:   side0_nxt.simple = value_i[15] ? '0 : value_i;
      OP_LEAKY:  side0_nxt.simple = value_i[15] ? fx_t'(lk_sh[15:0]) : value_i;
      default:   side0_nxt.simple = value_i;
    endcase
    ez0_nxt = ({4'b0, side0_nxt.mag} >= EZ_LIM);
    t0_nxt  = 27'({16'b0, side0_nxt.mag} << T_SHIFT);
  end

  always_ff @(posedge clk) begin
    side0_r <= side0_nxt;
    ez0_r   <= ez0_nxt;
    t0_r    <= t0_nxt;
  end

  // stage 1: t^2
  side_t       side1_r;
  logic        ez1_r;
  logic [26:0] t1_r;
  logic [22:0] p2_1_r;
  logic [53:0] sq_t;

  assign sq_t = 54'(t0_r) * 54'(t0_r);

  always_ff @(posedge clk) begin
    side1_r <= side0_r;
    ez1_r   <= ez0_r;
    t1_r    <= t0_r;
    p2_1_r  <= sq_t[53:31];
  end

  // stage 2: t^3
  side_t       side2_r;
  logic        ez2_r;
  logic [26:0] t2_r;
  logic [22:0] p2_2_r;
  logic [18:0] p3_2_r;
  logic [49:0] cu_t;

  assign cu_t = 50'(p2_1_r) * 50'(t1_r);

  always_ff @(posedge clk) begin
    side2_r <= side1_r;
    ez2_r   <= ez1_r;
    t2_r    <= t1_r;
    p2_2_r  <= p2_1_r;
    p3_2_r  <= cu_t[49:31];
  end

  // stage 3: t^4 and t^3/6 by reciprocal
  side_t       side3_r;
  logic        ez3_r;
  logic [26:0] t3_r;
  logic [22:0] p2_3_r;
  logic [14:0] p4_3_r;
  logic [16:0] d6_3_r;
  logic [45:0] qd_t;
  logic [38:0] d6_prod;

  assign qd_t    = 46'(p3_2_r) * 46'(t2_r);
  assign d6_prod = 39'(p3_2_r) * 39'(M6);

  always_ff @(posedge clk) begin
    side3_r <= side2_r;
    ez3_r   <= ez2_r;
    t3_r    <= t2_r;
    p2_3_r  <= p2_2_r;
    p4_3_r  <= qd_t[45:31];
    d6_3_r  <= d6_prod[38:22];
  end

  // stage 4: t^4/24 and partial sum
  side_t       side4_r;
  logic        ez4_r;
  logic [31:0] a4_r;
  logic [10:0] d24_4_r;
  logic [30:0] d24_prod;
  logic [32:0] a_nxt;

  assign d24_prod = 31'(p4_3_r) * 31'(M24);
  assign a_nxt    = Q31_ONE - 33'(t3_r) + 33'(p2_3_r >> 1) - 33'(d6_3_r);

  always_ff @(posedge clk) begin
    side4_r <= side3_r;
    ez4_r   <= ez3_r;
    a4_r    <= a_nxt[31:0];
    d24_4_r <= d24_prod[30:20];
  end

  // stage 5: series result, forced to zero for large inputs
  side_t       side5_r;
  logic [31:0] e5_r;

  always_ff @(posedge clk) begin
    side5_r <= side4_r;
    e5_r    <= ez4_r ? '0 : a4_r + 32'(d24_4_r);
  end

  assign side_o = side5_r;
  assign e0_o   = e5_r;

endmodule

// ===== rtl/nau_exp.sv =====
// eight q31 squarings: raises the series value to the 256th power
module nau_exp (
  input  logic            clk,
  input  nau_pkg::side_t  side_i,
  input  logic [31:0]     e_i,
  output nau_pkg::side_t  side_o,
  output logic [31:0]     e_o
);
  import nau_pkg::*;

  localparam int NSQ = 8;

  side_t       side_r [NSQ];
  logic [31:0] e_r    [NSQ];

  for (genvar k = 0; k < NSQ; k++) begin : g_sq
    logic [31:0] e_in;
    side_t       side_in;
    logic [63:0] prod;

    if (k == 0) begin : g_first
      assign e_in    = e_i;
      assign side_in = side_i;
    end else begin : g_next
      assign e_in    = e_r[k-1];
      assign side_in = side_r[k-1];
    end

    assign prod = 64'(e_in) * 64'(e_in);

    always_ff @(posedge clk) begin
      e_r[k]    <= prod[62:31];
      side_r[k] <= side_in;
    end
  end

  assign side_o = side_r[NSQ-1];
  assign e_o    = e_r[NSQ-1];

endmodule

// ===== rtl/nau_div.sv =====
// divide setup and pipelined restoring divider, one quotient bit per stage
module nau_div (
  input  logic               clk,
  input  nau_pkg::side_t     side_i,
  input  logic [31:0]        e_i,
  output nau_pkg::side_t     side_o,
  output logic [nau_pkg::QW-1:0] q_o
);
  import nau_pkg::*;

  localparam int          CMPW    = DIVW + 2;
  localparam logic [31:0] Q31_ONE = 32'h8000_0000;

  logic [DIVW-1:0] rem_r  [QW];
  logic [DSRW-1:0] den_r  [QW];
  side_t           side_r [QW+1];
  logic [QW-1:0]   q_r    [1:QW];

  // setup: tanh uses (1-e)/(1+e) rounded, sigmoid uses |x|/(1+|x|)
  logic [31:0]     th_num;
  logic [DSRW-1:0] th_den, sg_den;
  logic [DIVW-1:0] th_dvd, sg_dvd;

  always_comb begin
    th_num = Q31_ONE - e_i;
    th_den = DSRW'(Q31_ONE) + DSRW'(e_i);
    th_dvd = (DIVW'(th_num) << FRAC_BITS) + DIVW'(th_den >> 1);
    sg_dvd = DIVW'(side_i.mag) << FRAC_BITS;
    sg_den = DSRW'(1 << FRAC_BITS) + DSRW'(side_i.mag);
  end

  always_ff @(posedge clk) begin
    side_r[0] <= side_i;
    if (side_i.op == OP_TANH) begin
      rem_r[0] <= th_dvd;
      den_r[0] <= th_den;
    end else begin
      rem_r[0] <= sg_dvd;
      den_r[0] <= sg_den;
    end
  end

  for (genvar j = 1; j <= QW; j++) begin : g_step
    localparam int BIT = QW - j;
    logic [CMPW-1:0] trial;
    logic            borrow;
    logic [QW-1:0]   q_prev;

    if (j == 1) begin : g_first
      assign q_prev = '0;
    end else begin : g_next
      assign q_prev = q_r[j-1];
    end

    assign trial  = CMPW'(rem_r[j-1]) - (CMPW'(den_r[j-1]) << BIT);
    assign borrow = trial[CMPW-1];

    always_ff @(posedge clk) begin
      side_r[j] <= side_r[j-1];
      q_r[j]    <= {q_prev[QW-2:0], ~borrow};
    end

    if (j < QW) begin : g_rem
      always_ff @(posedge clk) begin
        rem_r[j] <= borrow ? rem_r[j-1] : trial[DIVW-1:0];
        den_r[j] <= den_r[j-1];
      end
    end
  end

  assign side_o = side_r[QW];
  assign q_o    = q_r[QW];

endmodule

// ===== rtl/nau_ofifo.sv =====
// result queue with registered read and credit count for input flow control
module nau_ofifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             acc_i,
  input  logic             wr_en_i,
  input  nau_pkg::fx_t     wr_data_i,
  output logic             in_ready_o,
  nau_out_if.source        out_word
);
  import nau_pkg::*;

  fx_t                mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_AW:0]   fill_r, fill_nxt;
  logic [FIFO_AW:0]   credit_r, credit_nxt;
  logic               ov_r;
  fx_t                od_r;
  logic               load, deliver;

  assign deliver = ov_r && out_word.ready;
  assign load    = (fill_r != '0) && (!ov_r || out_word.ready);

  always_comb begin
    fill_nxt   = fill_r + (FIFO_AW+1)'(wr_en_i) - (FIFO_AW+1)'(load);
    credit_nxt = credit_r + (FIFO_AW+1)'(acc_i) - (FIFO_AW+1)'(deliver);
  end

  always_ff @(posedge clk) begin
    if (wr_en_i) begin
      mem[wr_ptr_r] <= wr_data_i;
    end
    if (load) begin
      od_r <= mem[rd_ptr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
      credit_r <= '0;
      ov_r     <= 1'b0;
    end else begin
      if (wr_en_i) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (load)    rd_ptr_r <= rd_ptr_r + 1'b1;
      fill_r   <= fill_nxt;
      credit_r <= credit_nxt;
      if (load) begin
        ov_r <= 1'b1;
      end else if (out_word.ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  // full window means every queue slot is spoken for
  assign in_ready_o      = ~credit_r[FIFO_AW];
  assign out_word.valid  = ov_r;
  assign out_word.result = od_r;

endmodule

// ===== rtl/neural_activation_unit.sv =====
// top level: activation unit with linear, fast sigmoid, relu, leaky relu and tanh
// path: each accepted word passes the NSTG register stages (NSTG = 28), then the queue memory and its read register
// throughput: one word per cycle while in_word.ready is high; the arithmetic pipeline never stalls
// flow control: in_word.ready drops once FIFO_DEPTH (32) words are in flight
// reset: synchronous active-low rst_n clears valid bits, queue pointers and credits
// payload registers are not reset
module neural_activation_unit (
  input  logic      clk,
  input  logic      rst_n,
  nau_in_if.sink    in_word,
  nau_out_if.source out_word
);
  import nau_pkg::*;

  // input handshake; the queue grants credit only when a slot is reserved
  logic in_ready;
  logic in_acc;

  assign in_word.ready = in_ready;
  assign in_acc        = in_word.valid && in_ready;

  // valid bits march alongside the data, one per register stage
  logic [NSTG-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[NSTG-2:0], in_acc};
    end
  end

  // front end: decode, simple functions, exp series (stages 0..5)
  side_t       fr_side;
  logic [31:0] fr_e0;

  nau_front u_front (
    .clk     (clk),
    .op_i    (in_word.operation),
    .value_i (in_word.value),
    .side_o  (fr_side),
    .e0_o    (fr_e0)
  );

  // repeated squaring gives exp(-2|x|) in q31 (stages 6..13)
  side_t       ex_side;
  logic [31:0] ex_e;

  nau_exp u_exp (
    .clk    (clk),
    .side_i (fr_side),
    .e_i    (fr_e0),
    .side_o (ex_side),
    .e_o    (ex_e)
  );

  // shared divider: tanh ratio or fast sigmoid quotient (stages 14..NSTG-1)
  side_t         dv_side;
  logic [QW-1:0] dv_q;

  nau_div u_div (
    .clk    (clk),
    .side_i (ex_side),
    .e_i    (ex_e),
    .side_o (dv_side),
    .q_o    (dv_q)
  );

  // sign, saturation and function select, written straight into the queue
  logic [16:0] qx;
  logic [16:0] qx_neg;
  fx_t         pos_sat, neg_sat, res;

  always_comb begin
    qx      = 17'(dv_q);
    qx_neg  = ~qx + 17'd1;
    pos_sat = (qx > 17'd32767) ? 16'sh7fff : fx_t'(qx[15:0]);
    neg_sat = (qx > 17'd32768) ? 16'sh8000 : fx_t'(qx_neg[15:0]);
    case (dv_side.op) inside
      OP_SIGMOID, OP_TANH: res = dv_side.neg ? neg_sat : pos_sat;
      default:             res = dv_side.simple;
    endcase
  end

  // result queue decouples the pipeline from the output handshake
  nau_ofifo u_ofifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc_i      (in_acc),
    .wr_en_i    (vld_r[NSTG-1]),
    .wr_data_i  (res),
    .in_ready_o (in_ready),
    .out_word   (out_word)
  );

endmodule
